>>> rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

	localparam int MAX_FRAME_BYTES = 38;
	localparam int BYTE_CAP        = (MAX_FRAME_BYTES < 63) ? MAX_FRAME_BYTES : 63;
	localparam int CNT_W           = 6;
	localparam int PAY_FIRST       = 4;
	localparam int PAY_DEPTH       = 32;
	localparam int PAY_AW          = $clog2(PAY_DEPTH);
	localparam int TYPE_POS        = 3;
	localparam int FIELD_W         = 4;
	localparam int VALUE_W         = 32;
	localparam int IN_DATA_W       = 8;
	localparam int IN_USER_W       = 1;
	localparam int OUT_DATA_W      = ((FIELD_W + VALUE_W + 7) / 8) * 8;
	localparam int OUT_USER_W      = 3;
	localparam int CFG_INDEX_W     = 1;
	localparam int CFG_DATA_W      = 8;
	localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
	localparam logic [7:0] SONAR_LIMIT_RST = 8'd40;

	typedef enum logic [1:0] {
		KIND_ODOM    = 2'd0,
		KIND_IMU     = 2'd1,
		KIND_SONAR   = 2'd2,
		KIND_BATTERY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_CRC  = 2'd1,
		ST_TYPE = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KIND        = 1'b0,
		REG_SONAR_LIMIT = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		kind_t   kind;
	} rx_done_t;

	function automatic logic [CNT_W-1:0] frame_len(input kind_t kind);
		logic [CNT_W-1:0] len;
		unique case (kind)
			KIND_ODOM:    len = CNT_W'(14);
			KIND_IMU:     len = CNT_W'(38);
			KIND_SONAR:   len = CNT_W'(10);
			KIND_BATTERY: len = CNT_W'(10);
			default:      len = CNT_W'(14);
		endcase
		return len;
	endfunction

	function automatic logic [7:0] frame_type(input kind_t kind);
		logic [7:0] t;
		unique case (kind)
			KIND_ODOM:    t = 8'h12;
			KIND_IMU:     t = 8'h14;
			KIND_SONAR:   t = 8'h1A;
			KIND_BATTERY: t = 8'h08;
			default:      t = 8'h12;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
		end
		return c;
	endfunction

	// bytes per field: 1, 2 or 4
	function automatic logic [2:0] field_bytes(input kind_t kind, input logic [FIELD_W-1:0] fld);
		logic [2:0] nb;
		unique case (kind)
			KIND_IMU:   nb = (fld < FIELD_W'(6)) ? 3'd4 : 3'd2;
			KIND_SONAR: nb = 3'd1;
			default:    nb = 3'd2;
		endcase
		return nb;
	endfunction

	function automatic logic [FIELD_W-1:0] field_count(input kind_t kind);
		logic [FIELD_W-1:0] n;
		unique case (kind)
			KIND_ODOM:    n = FIELD_W'(4);
			KIND_IMU:     n = FIELD_W'(10);
			KIND_SONAR:   n = FIELD_W'(4);
			KIND_BATTERY: n = FIELD_W'(2);
			default:      n = FIELD_W'(4);
		endcase
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] read_total(input kind_t kind);
		logic [CNT_W-1:0] n;
		unique case (kind)
			KIND_ODOM:    n = CNT_W'(8);
			KIND_IMU:     n = CNT_W'(32);
			KIND_SONAR:   n = CNT_W'(4);
			KIND_BATTERY: n = CNT_W'(4);
			default:      n = CNT_W'(8);
		endcase
		return n;
	endfunction

endpackage

>>> rtl/core/sensor_frame_deframer_crc8_unit.sv
`timescale 1ns / 1ps

// Response frame deframer with CRC-8 (reflected 0x8C) check.
// Input stream: one frame byte per transaction in s_axis_tdata, s_axis_tuser
// marks the first byte of a frame. Bytes are taken one per cycle while the
// block collects a frame; CRC, position count and type byte sit in flops, the
// payload bytes go into a 32 x 8 synchronous RAM.
// On the final byte of a frame the block either queues one error result
// (status CRC or type) or walks the payload RAM, one read per cycle while the
// receiver takes results, building each field from 1, 2 or 4 bytes. An error
// result passes through the error state into the output register; a field is
// loaded into the output register from the RAM read register once its last
// byte has been read.
// While results are produced s_axis_tready is low; the next frame starts
// once the last result sits in the output register.
// A stalled receiver holds the output register and pauses the RAM walk.
// Config writes (index 0 kind, 1 sonar limit) are taken every cycle and must
// only happen while no frame is in flight.
// Reset clears counters, CRC, type byte, config and output valid; the payload
// RAM is not cleared and needs no clearing pass.
module sensor_frame_deframer_crc8_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [sfd_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
	input  logic [sfd_pkg::IN_USER_W-1:0]   s_axis_tuser,  // [0] frame_start
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [sfd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [3:0] field_index, [35:4] field_value
	output logic [sfd_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // [0] beyond_range, [2:1] status
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sfd_pkg::*;

	kind_t              kind_q;
	logic [7:0]         sonar_limit_q;
	logic               in_accept;
	logic               emit_busy;
	rx_done_t           rx_done;
	logic               wr_en;
	logic [PAY_AW-1:0]  wr_addr;
	logic [7:0]         wr_data;
	logic               rd_en;
	logic [PAY_AW-1:0]  rd_addr;
	logic [7:0]         rd_data;
	logic [FIELD_W-1:0] out_index;
	logic [VALUE_W-1:0] out_value;
	logic               out_beyond;
	status_t            out_status;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !emit_busy;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q        <= KIND_ODOM;
			sonar_limit_q <= SONAR_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_KIND:        kind_q <= kind_t'(cfg_data[1:0]);
				REG_SONAR_LIMIT: sonar_limit_q <= cfg_data;
				default:         sonar_limit_q <= sonar_limit_q;
			endcase
		end
	end

	sfd_rx u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.rx_byte    (s_axis_tdata[7:0]),
		.frame_start(s_axis_tuser[0]),
		.kind       (kind_q),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.done       (rx_done)
	);

	sfd_ram #(
		.WIDTH(8),
		.DEPTH(PAY_DEPTH)
	) u_payload_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	sfd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.done       (rx_done),
		.sonar_limit(sonar_limit_q),
		.busy       (emit_busy),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_index  (out_index),
		.out_value  (out_value),
		.out_beyond (out_beyond),
		.out_status (out_status),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {(OUT_DATA_W - FIELD_W - VALUE_W)'(0), out_value, out_index};
	assign m_axis_tuser = {out_status, out_beyond};

`ifndef ASSERT_OFF
	a_done_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rx_done.valid |-> in_accept)
		else $error("frame end seen without an input transaction");

	a_error_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_status != ST_OK) |->
		(m_axis_tlast && out_index == '0 && out_value == '0 && !out_beyond))
		else $error("error result carries field data or is not last");

	a_beyond_only_sonar_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_beyond) |-> (out_status == ST_OK))
		else $error("beyond_range set on an error result");

	a_no_ram_write_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en)
		else $error("payload RAM written during field walk");
`endif

endmodule

>>> rtl/core/sfd_ram.sv
`timescale 1ns / 1ps

module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/sfd_rx.sv
`timescale 1ns / 1ps

module sfd_rx (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_accept,
	input  logic [7:0]                 rx_byte,
	input  logic                       frame_start,
	input  sfd_pkg::kind_t             kind,
	output logic                       wr_en,
	output logic [sfd_pkg::PAY_AW-1:0] wr_addr,
	output logic [7:0]                 wr_data,
	output sfd_pkg::rx_done_t          done
);
	import sfd_pkg::*;

	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       crc_q;
	logic [7:0]       type_q;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] pay_off;
	logic [CNT_W:0]   pos_next;
	logic [CNT_W:0]   len_ext;
	logic [7:0]       crc_base;
	logic             in_body;
	logic             is_final;

	always_comb begin
		pos      = frame_start ? '0 : byte_count_q;
		crc_base = frame_start ? 8'h00 : crc_q;
		pos_next = {1'b0, pos} + (CNT_W+1)'(1);
		len_ext  = {1'b0, frame_len(kind)};
		in_body  = pos_next < len_ext;
		is_final = pos_next == len_ext;
		pay_off  = pos - CNT_W'(PAY_FIRST);
	end

	assign wr_en   = in_accept && in_body && (pos >= CNT_W'(PAY_FIRST))
		&& (pay_off < CNT_W'(PAY_DEPTH));
	assign wr_addr = pay_off[PAY_AW-1:0];
	assign wr_data = rx_byte;

	// CRC check wins over the type check
	always_comb begin
		done.valid = in_accept && is_final;
		done.kind  = kind;
		if (rx_byte != crc_base) begin
			done.status = ST_CRC;
		end else if (type_q != frame_type(kind)) begin
			done.status = ST_TYPE;
		end else begin
			done.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			crc_q        <= '0;
			type_q       <= '0;
		end else if (in_accept) begin
			byte_count_q <= (pos < CNT_W'(BYTE_CAP)) ? pos + CNT_W'(1) : pos;
			crc_q        <= in_body ? crc8_update(crc_base, rx_byte) : crc_base;
			if (in_body && pos == CNT_W'(TYPE_POS)) begin
				type_q <= rx_byte;
			end
		end
	end

endmodule

>>> rtl/core/sfd_emit.sv
`timescale 1ns / 1ps

module sfd_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfd_pkg::rx_done_t           done,
	input  logic [7:0]                  sonar_limit,
	output logic                        busy,
	output logic                        rd_en,
	output logic [sfd_pkg::PAY_AW-1:0]  rd_addr,
	input  logic [7:0]                  rd_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sfd_pkg::FIELD_W-1:0] out_index,
	output logic [sfd_pkg::VALUE_W-1:0] out_value,
	output logic                        out_beyond,
	output sfd_pkg::status_t            out_status,
	output logic                        out_last
);
	import sfd_pkg::*;

	typedef enum logic [2:0] {
		S_COLLECT = 3'b001,
		S_ERROR   = 3'b010,
		S_EMIT    = 3'b100
	} emit_state_t;

	emit_state_t         state_q;
	kind_t               kind_q;
	status_t             err_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic                pend_q;
	logic [FIELD_W-1:0]  fld_q;
	logic [1:0]          fb_q;
	logic [23:0]         acc_q;
	logic                out_valid_q;
	logic [FIELD_W-1:0]  out_index_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic                out_beyond_q;
	status_t             out_status_q;
	logic                out_last_q;

	logic                out_free;
	logic [2:0]          nb;
	logic                field_end;
	logic                last_field;
	logic                consume;
	logic                issue;
	logic                load_err;
	logic                load_fld;
	logic [VALUE_W-1:0]  fld_value;

	always_comb begin
		out_free   = !out_valid_q || out_ready;
		nb         = field_bytes(kind_q, fld_q);
		field_end  = ({1'b0, fb_q} + 3'd1) == nb;
		last_field = fld_q == (field_count(kind_q) - FIELD_W'(1));
		// a finished field waits in the RAM read register until the output frees up
		consume    = (state_q == S_EMIT) && pend_q && (!field_end || out_free);
		issue      = (state_q == S_EMIT) && (rd_cnt_q < read_total(kind_q))
			&& (!pend_q || consume);
		load_err   = (state_q == S_ERROR) && out_free;
		load_fld   = consume && field_end;
		unique case (nb)
			3'd1:    fld_value = {24'h0, rd_data};
			3'd2:    fld_value = {{16{acc_q[7]}}, acc_q[7:0], rd_data};
			default: fld_value = {acc_q, rd_data};
		endcase
	end

	assign busy    = state_q != S_COLLECT;
	assign rd_en   = issue;
	assign rd_addr = rd_cnt_q[PAY_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			kind_q      <= KIND_ODOM;
			err_q       <= ST_OK;
			rd_cnt_q    <= '0;
			pend_q      <= 1'b0;
			fld_q       <= '0;
			fb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_err || load_fld) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				S_COLLECT: begin
					if (done.valid) begin
						kind_q   <= done.kind;
						err_q    <= done.status;
						rd_cnt_q <= '0;
						pend_q   <= 1'b0;
						fld_q    <= '0;
						fb_q     <= '0;
						state_q  <= (done.status == ST_OK) ? S_EMIT : S_ERROR;
					end
				end
				S_ERROR: begin
					if (load_err) begin
						state_q <= S_COLLECT;
					end
				end
				S_EMIT: begin
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end
					pend_q <= issue || (pend_q && !consume);
					if (consume) begin
						if (field_end) begin
							fb_q  <= '0;
							fld_q <= fld_q + FIELD_W'(1);
							if (last_field) begin
								state_q <= S_COLLECT;
							end
						end else begin
							fb_q <= fb_q + 2'd1;
						end
					end
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (consume && !field_end) begin
			acc_q <= {acc_q[15:0], rd_data};
		end
		if (load_err) begin
			out_index_q  <= '0;
			out_value_q  <= '0;
			out_beyond_q <= 1'b0;
			out_status_q <= err_q;
			out_last_q   <= 1'b1;
		end else if (load_fld) begin
			out_index_q  <= fld_q;
			out_value_q  <= fld_value;
			out_beyond_q <= (kind_q == KIND_SONAR) && (rd_data > sonar_limit);
			out_status_q <= ST_OK;
			out_last_q   <= last_field;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_index  = out_index_q;
	assign out_value  = out_value_q;
	assign out_beyond = out_beyond_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule
